// ===== rtl/rrc_pkg.sv =====
// shared types and constants of the ratiometric resistance converter
// no dependencies; used by every module of the block
`default_nettype none

package rrc_pkg;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned TAG_W   = 3;
  localparam int unsigned REF_W   = 16;
  localparam int unsigned RES_W   = 31;
  localparam int unsigned REFK_W  = 26;  // ref * 1000
  localparam int unsigned DIFF_W  = 15;  // code - zero for the mid range
  localparam int unsigned DIV_W   = 15;  // 65536 - code for the mid range
  localparam int unsigned NUM_W   = REFK_W + DIFF_W;
  localparam int unsigned QUOT_W  = 36;  // divisor >= 33 keeps the top bits below it
  localparam int unsigned REM_W   = DIV_W;
  localparam int unsigned HV_W    = 37;  // ref * 2000000

  localparam logic [CODE_W-1:0] CODE_ZERO       = 16'd32768;
  localparam logic [CODE_W-1:0] CODE_LOW_LIMIT  = 16'd32800;
  localparam logic [CODE_W-1:0] CODE_HIGH_LIMIT = 16'd65504;
  localparam logic [9:0]        MOHM_PER_OHM    = 10'd1000;
  localparam logic [20:0]       HIGH_FACTOR     = 21'd2000000;
  localparam logic [RES_W-1:0]  RESULT_MAX      = 31'h7fff_ffff;

  // reset value of the reference (2000 ohm) in its derived forms
  localparam logic [REFK_W-1:0] REFK_RESET  = 26'd2000000;
  localparam logic [RES_W-1:0]  HV_RESET    = 31'h7fff_ffff;
  localparam logic              HSAT_RESET  = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]  channel_tag;
    logic [CODE_W-1:0] raw_code;
  } in_word_t;

  typedef struct packed {
    logic [TAG_W-1:0] channel_out;
    logic [RES_W-1:0] resistance_mohm;
    logic             low_clamp;
    logic             high_clamp;
  } out_word_t;

  // word handed from cell to cell of the divider chain
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              lo;
    logic              hi;
    logic [DIV_W-1:0]  div;
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] nq;   // numerator bits shift out, quotient bits shift in
  } div_word_t;

  // high-end result, derived from the reference at write time
  typedef struct packed {
    logic [RES_W-1:0] value;
    logic             sat;
  } high_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rrc_front.sv =====
// config register and multiply stage feeding the divider chain
// depends on rrc_pkg
`default_nettype none

module rrc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_keep_i,
  input  wire rrc_pkg::in_word_t  in_word_i,
  output      logic               in_ready_o,
  output      logic               dn_valid_o,
  output      rrc_pkg::div_word_t dn_word_o,
  input  wire logic               dn_ready_i,
  output      rrc_pkg::high_cfg_t high_cfg_o
);

  logic [rrc_pkg::REFK_W-1:0] refk_q, refk_d;
  rrc_pkg::high_cfg_t         high_q, high_d;
  logic [rrc_pkg::HV_W-1:0]   hv_full;

  always_comb begin
    refk_d       = rrc_pkg::REFK_W'(cfg_wdata_i) * rrc_pkg::REFK_W'(rrc_pkg::MOHM_PER_OHM);
    hv_full      = rrc_pkg::HV_W'(cfg_wdata_i) * rrc_pkg::HV_W'(rrc_pkg::HIGH_FACTOR);
    high_d.sat   = hv_full > rrc_pkg::HV_W'(rrc_pkg::RESULT_MAX);
    high_d.value = high_d.sat ? rrc_pkg::RESULT_MAX : hv_full[rrc_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refk_q       <= rrc_pkg::REFK_RESET;
      high_q.value <= rrc_pkg::HV_RESET;
      high_q.sat   <= rrc_pkg::HSAT_RESET;
    end else if (cfg_valid_i) begin
      refk_q <= refk_d;
      high_q <= high_d;
    end
  end

  assign high_cfg_o = high_q;

  // operand prep and the one multiplication
  logic [rrc_pkg::DIFF_W-1:0] diff;
  logic [rrc_pkg::CODE_W-1:0] span;
  logic [rrc_pkg::NUM_W-1:0]  num;
  rrc_pkg::div_word_t         word_d, word_q;
  logic                       valid_q;

  always_comb begin
    diff        = rrc_pkg::DIFF_W'(in_word_i.raw_code - rrc_pkg::CODE_ZERO);
    span        = ~in_word_i.raw_code + 16'd1;
    num         = rrc_pkg::NUM_W'(refk_q) * rrc_pkg::NUM_W'(diff);
    word_d.tag  = in_word_i.channel_tag;
    word_d.lo   = in_word_i.raw_code <= rrc_pkg::CODE_LOW_LIMIT;
    word_d.hi   = in_word_i.raw_code >= rrc_pkg::CODE_HIGH_LIMIT;
    word_d.div  = span[rrc_pkg::DIV_W-1:0];
    word_d.rem  = rrc_pkg::REM_W'(num[rrc_pkg::NUM_W-1:rrc_pkg::QUOT_W]);
    word_d.nq   = num[rrc_pkg::QUOT_W-1:0];
  end

  assign in_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i && in_keep_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_word_o  = word_q;

endmodule

`default_nettype wire

// ===== rtl/rrc_cell.sv =====
// one restoring-division cell: one quotient bit per word, registered
// depends on rrc_pkg
`default_nettype none

module rrc_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               up_valid_i,
  input  wire rrc_pkg::div_word_t up_word_i,
  output      logic               up_ready_o,
  output      logic               dn_valid_o,
  output      rrc_pkg::div_word_t dn_word_o,
  input  wire logic               dn_ready_i
);

  logic                       valid_q;
  rrc_pkg::div_word_t         word_q, word_d;
  logic [rrc_pkg::REM_W:0]    rem_sh;
  logic                       take;

  always_comb begin
    rem_sh    = {up_word_i.rem, up_word_i.nq[rrc_pkg::QUOT_W-1]};
    take      = rem_sh >= {1'b0, up_word_i.div};
    word_d    = up_word_i;
    word_d.rem = take ? rrc_pkg::REM_W'(rem_sh - {1'b0, up_word_i.div})
                      : rem_sh[rrc_pkg::REM_W-1:0];
    word_d.nq  = {up_word_i.nq[rrc_pkg::QUOT_W-2:0], take};
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      word_q <= word_d;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_word_o  = word_q;

endmodule

`default_nettype wire

// ===== rtl/ratiometric_adc_to_resistance_core.sv =====
// top level: front multiply stage, divider cell chain, output register
// depends on rrc_pkg, rrc_front, rrc_cell
`default_nettype none

// Converts an offset-binary ADC code from a sensor/reference divider into the
// sensor resistance in milliohms, ref*1000*(code-32768)/(65536-code), truncated.
// Codes at or below 32800 give 0 with low_clamp; codes at or above 65504 give
// ref*2000000 with high_clamp; results above 2^31-1 saturate with high_clamp.
// Throughput is one word per clock while the output is not stalled. The input
// accept edge loads the multiply stage, then a chain of 36 division cells
// (one quotient bit each) and the output register follow. Backpressure
// moves cell by cell, so bubbles fill while a result waits. Words whose
// channel tag is not below CHANNELS are taken and dropped. Write the
// reference only while idle.

module ratiometric_adc_to_resistance_core #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire rrc_pkg::in_word_t  in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      rrc_pkg::out_word_t out_data_o
);

  localparam int unsigned NCELL = rrc_pkg::QUOT_W;

  logic                  tag_ok;
  logic                  v   [NCELL+1];
  logic                  rdy [NCELL+1];
  rrc_pkg::div_word_t    w   [NCELL+1];
  rrc_pkg::high_cfg_t    high_cfg;

  assign cfg_ready_o = 1'b1;
  assign tag_ok      = {6'd0, in_data_i.channel_tag} < 9'(CHANNELS);

  rrc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_keep_i  (tag_ok),
    .in_word_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .dn_valid_o (v[0]),
    .dn_word_o  (w[0]),
    .dn_ready_i (rdy[0]),
    .high_cfg_o (high_cfg)
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rrc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .up_valid_i(v[i]),
      .up_word_i (w[i]),
      .up_ready_o(rdy[i]),
      .dn_valid_o(v[i+1]),
      .dn_word_o (w[i+1]),
      .dn_ready_i(rdy[i+1])
    );
  end

  // output stage: clamps and saturation
  logic               out_valid_q;
  rrc_pkg::out_word_t out_q, out_d;
  rrc_pkg::div_word_t last;
  logic               over;

  assign last = w[NCELL];
  assign over = |last.nq[rrc_pkg::QUOT_W-1:rrc_pkg::RES_W];
  assign rdy[NCELL] = !out_valid_q || out_ready_i;

  always_comb begin
    out_d.channel_out = last.tag;
    out_d.low_clamp   = last.lo;
    if (last.lo) begin
      out_d.resistance_mohm = '0;
      out_d.high_clamp      = 1'b0;
    end else if (last.hi) begin
      out_d.resistance_mohm = high_cfg.value;
      out_d.high_clamp      = 1'b1;
    end else if (over) begin
      out_d.resistance_mohm = rrc_pkg::RESULT_MAX;
      out_d.high_clamp      = 1'b1;
    end else begin
      out_d.resistance_mohm = last.nq[rrc_pkg::RES_W-1:0];
      out_d.high_clamp      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[NCELL]) begin
      out_valid_q <= v[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NCELL] && v[NCELL]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/rrc_checker.sv =====
// port-level checks for the resistance converter, bound to the top level
// depends on rrc_pkg and ratiometric_adc_to_resistance_core
`default_nettype none

module rrc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire rrc_pkg::out_word_t out_data_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // input only backs up when the whole chain is full and the output stalls
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  // low clamp forces a zero result
  a_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.low_clamp |-> out_data_o.resistance_mohm == '0)
    else $error("low clamp with nonzero result");

  // the two clamps never come together
  a_clamp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.low_clamp && out_data_o.high_clamp))
    else $error("both clamp flags set");

endmodule

bind ratiometric_adc_to_resistance_core rrc_checker u_rrc_checker (.*);

`default_nettype wire

// ===== sim/ratiometric_adc_to_resistance_core_tb.sv =====
// self-checking bench for ratiometric_adc_to_resistance_core: directed and random adc samples,
// reference rewrites between phases, random idling and one long output stall
// depends on rrc_pkg and the core rtl
module ratiometric_adc_to_resistance_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] MID_CODE    = 16'd32768;
  localparam logic [15:0] FLOOR_CODE  = 16'd32800;
  localparam logic [15:0] CEIL_CODE   = 16'd65504;
  localparam logic [63:0] MOHM_SCALE  = 64'd1000;
  localparam logic [63:0] CEIL_FACTOR = 64'd2000000;
  localparam logic [63:0] MOHM_SAT    = 64'd2147483647;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 200;
  localparam int unsigned SETTLE      = 45;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [15:0] cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  rrc_pkg::in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  rrc_pkg::out_word_t out_data_o;

  rrc_pkg::in_word_t  pending_samples[$];
  rrc_pkg::out_word_t expected_readings[$];
  logic [15:0] ref_ohms = 16'd2000;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  logic        stall_req = 1'b0;
  logic        hold_off  = 1'b0;

  ratiometric_adc_to_resistance_core #(
    .CHANNELS(8)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // milliohms for one sample at a given reference, with clamp flags
  function automatic rrc_pkg::out_word_t resistance_of(input rrc_pkg::in_word_t w,
                                                       input logic [15:0] ohms);
    rrc_pkg::out_word_t r;
    logic [63:0]        value;
    r.channel_out     = w.channel_tag;
    r.resistance_mohm = '0;
    r.low_clamp       = 1'b0;
    r.high_clamp      = 1'b0;
    if (w.raw_code <= FLOOR_CODE) begin
      r.low_clamp = 1'b1;
      return r;
    end
    if (w.raw_code >= CEIL_CODE) begin
      r.high_clamp = 1'b1;
      value = 64'(ohms) * CEIL_FACTOR;
    end else begin
      value = (64'(ohms) * MOHM_SCALE * 64'(w.raw_code - MID_CODE))
              / (64'd65536 - 64'(w.raw_code));
    end
    if (value > MOHM_SAT) begin
      value = MOHM_SAT;
      r.high_clamp = 1'b1;
    end
    r.resistance_mohm = value[30:0];
    return r;
  endfunction

  // weighted toward the clamp edges and the steep top of the curve
  function automatic rrc_pkg::in_word_t random_sample();
    rrc_pkg::in_word_t w;
    w.channel_tag = 3'($urandom_range(7));
    case ($urandom_range(9))
      0, 1: w.raw_code = 16'($urandom);
      2: w.raw_code = 16'($urandom_range(32832, 32760));
      3: w.raw_code = 16'($urandom_range(65535, 65472));
      4: w.raw_code = 16'($urandom_range(32800, 0));
      5: w.raw_code = 16'($urandom_range(65503, 64000));
      default: w.raw_code = 16'($urandom_range(65503, 32801));
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reference(input logic [15:0] ohms);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= ohms;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ref_ohms = ohms;
  endtask

  // sender: predict on accept, then offer the next word or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_readings.push_back(resistance_of(in_data_i, ref_ohms));
      if (!in_valid_i || in_ready_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_samples.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each word with the oldest expectation
  always @(posedge clk_i) begin
    rrc_pkg::out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data_o));
        end else begin
          want = expected_readings.pop_front();
          if (out_data_o.channel_out !== want.channel_out)
            report_mismatch($sformatf("channel_out got %0d want %0d",
                                      out_data_o.channel_out, want.channel_out));
          if (out_data_o.resistance_mohm !== want.resistance_mohm)
            report_mismatch($sformatf("resistance_mohm got %0d want %0d",
                                      out_data_o.resistance_mohm, want.resistance_mohm));
          if (out_data_o.low_clamp !== want.low_clamp)
            report_mismatch($sformatf("low_clamp got %b want %b",
                                      out_data_o.low_clamp, want.low_clamp));
          if (out_data_o.high_clamp !== want.high_clamp)
            report_mismatch($sformatf("high_clamp got %b want %b",
                                      out_data_o.high_clamp, want.high_clamp));
        end
      end
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long output stall so the pipe fills and pushes back on the input
  initial begin
    wait (stall_req);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    logic [15:0]       phase_ref[PHASES];
    logic [15:0]       edge_codes[21];
    rrc_pkg::in_word_t w;
    phase_ref  = '{16'd1, 16'd65535, 16'd0, 16'd2000, 16'($urandom_range(65535, 1)),
                   16'($urandom_range(300, 1)), 16'($urandom_range(65535, 1)), 16'd65535};
    edge_codes = '{16'd0, 16'd1, 16'd32767, 16'd32768, 16'd32799, 16'd32800, 16'd32801,
                   16'd32802, 16'd32833, 16'd36000, 16'd40000, 16'd49151, 16'd49152,
                   16'd60000, 16'd65000, 16'd65503, 16'd65504, 16'd65505, 16'd65534,
                   16'd65535, 16'h7fff};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words at the reset reference
    send_idle_pct = 8;
    recv_idle_pct = 54;
    for (int i = 0; i < 21; i++) begin
      w.channel_tag = 3'(i);
      w.raw_code    = edge_codes[i];
      pending_samples.push_back(w);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reference(phase_ref[p]);
      if (p < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 54;
      end else if (p < 6) begin
        send_idle_pct = 54;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 6) stall_req <= 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++)
        pending_samples.push_back(random_sample());
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("ratiometric_adc_to_resistance_core: match");
    end else begin
      $display("ratiometric_adc_to_resistance_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ratiometric_adc_to_resistance_core: mismatch");
    $finish;
  end

endmodule
